>>> sv/bcdt_pkg.sv
// Shared types, key codes and digit limits for the BCD countdown timer.
package bcdt_pkg;

  localparam int unsigned NumDigits  = 6;
  localparam int unsigned CursorW    = 3;
  localparam logic [CursorW-1:0] LastCursor = CursorW'(NumDigits - 1);

  // Key characters recognized on a key press.
  localparam logic [7:0] KeyZero  = 8'h30;
  localparam logic [7:0] KeyNine  = 8'h39;
  localparam logic [7:0] KeyLeft  = 8'h3C;
  localparam logic [7:0] KeyRight = 8'h3E;

  // Action codes of an input item.
  localparam logic ActKey  = 1'b0;
  localparam logic ActTick = 1'b1;

  typedef logic [3:0] digit_t;
  typedef digit_t [NumDigits-1:0] digits_t;
  typedef logic [CursorW-1:0] cursor_t;

  // Outcome of one item: new state plus the status flags of the result.
  typedef struct packed {
    logic    accepted;
    logic    expired;
    digits_t digits;
    cursor_t cursor;
  } step_t;

  // Value a digit takes when a borrow passes through it: 5 for tens of
  // minutes and seconds, 9 for all ones digits and the hour tens.
  function automatic digit_t reload_value(input int unsigned pos);
    digit_t val;
    val = 4'd9;
    if (pos == 2 || pos == 4) begin
      val = 4'd5;
    end
    return val;
  endfunction

endpackage

>>> sv/bcdt_step.sv
// Next-state logic of the timer: digit entry, cursor moves and the borrow chain.
module bcdt_step
  import bcdt_pkg::*;
(
  input  logic    action,
  input  logic [7:0] key_code,
  input  digits_t digits,
  input  cursor_t cursor,
  output step_t   step
);

  digits_t dec_digits;
  logic    borrow_out;
  digit_t  key_offset;

  // Count down by one second: the borrow ripples up from the seconds ones
  // digit and stops at the first non-zero digit.
  always_comb begin
    logic borrow;
    borrow     = 1'b1;
    dec_digits = digits;
    for (int pos = NumDigits - 1; pos >= 0; pos--) begin
      if (borrow) begin
        if (digits[pos] != 4'd0) begin
          dec_digits[pos] = digits[pos] - 4'd1;
          borrow          = 1'b0;
        end else begin
          dec_digits[pos] = reload_value(pos);
        end
      end
    end
    borrow_out = borrow;
  end

  // Digit keys sit on a 16-aligned code, so the low nibble is the digit.
  assign key_offset = key_code[3:0] - KeyZero[3:0];

  // Select the effect of the item on the digits and the cursor.
  always_comb begin
    step.accepted = 1'b1;
    step.expired  = 1'b0;
    step.digits   = digits;
    step.cursor   = cursor;
    priority if (action == ActTick) begin
      // A tick at all zeros leaves the digits alone and flags expiry.
      if (borrow_out) begin
        step.expired = 1'b1;
      end else begin
        step.digits = dec_digits;
      end
    end else if (key_code >= KeyZero && key_code <= KeyNine) begin
      if (cursor <= LastCursor) begin
        step.digits[cursor] = key_offset;
      end
    end else if (key_code == KeyLeft) begin
      if (cursor != '0) begin
        step.cursor = cursor - CursorW'(1);
      end
    end else if (key_code == KeyRight) begin
      if (cursor < LastCursor) begin
        step.cursor = cursor + CursorW'(1);
      end
    end else begin
      step.accepted = 1'b0;
    end
  end

endmodule

>>> sv/bcd_countdown_timer_with_digit_entry.sv
// Top level of the BCD HH:MM:SS countdown timer with digit entry.
//
// Each input transfer (a key press or a one-second tick) yields exactly one
// result transfer with the status flags, the six digits and the edit cursor
// after that item. An item is held in the input register and then lands in
// the result register, and one item can be taken in every cycle while
// out_stall is low; the digit and cursor registers are updated as each item
// moves into the result register. While a result waits under out_stall, one
// more item can sit in the input register before in_stall rises. Reset clears
// the time to 00:00:00 and puts the cursor on the hour tens digit.
module bcd_countdown_timer_with_digit_entry
  import bcdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       action,
  input  logic [7:0] key_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       accepted,
  output logic [3:0] hour_tens,
  output logic [3:0] hour_ones,
  output logic [3:0] minute_tens,
  output logic [3:0] minute_ones,
  output logic [3:0] second_tens,
  output logic [3:0] second_ones,
  output logic [2:0] cursor_index,
  output logic       expired
);

  logic       stage_valid;
  logic       stage_action;
  logic [7:0] stage_key;
  digits_t    digits;
  cursor_t    cursor;
  step_t      step;
  logic       advance;
  logic       res_accepted;
  logic       res_expired;

  // The result slot is free when empty or when its transfer completes now.
  assign advance  = stage_valid && (!out_valid || !out_stall);
  assign in_stall = stage_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      stage_action <= action;
      stage_key    <= key_code;
    end
  end

  bcdt_step u_step (
    .action   (stage_action),
    .key_code (stage_key),
    .digits   (digits),
    .cursor   (cursor),
    .step     (step)
  );

  // Timer state doubles as the result's digit and cursor fields: it only
  // changes when the result slot is loaded.
  always_ff @(posedge clk) begin
    if (rst) begin
      digits <= '0;
      cursor <= '0;
    end else if (advance) begin
      digits <= step.digits;
      cursor <= step.cursor;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      res_accepted <= step.accepted;
      res_expired  <= step.expired;
    end
  end

  assign accepted     = res_accepted;
  assign expired      = res_expired;
  assign hour_tens    = digits[0];
  assign hour_ones    = digits[1];
  assign minute_tens  = digits[2];
  assign minute_ones  = digits[3];
  assign second_tens  = digits[4];
  assign second_ones  = digits[5];
  assign cursor_index = cursor;

  // The cursor never leaves the six digit positions.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    cursor <= LastCursor)
    else $error("edit cursor out of range");

  // Expiry is reported only as an accepted tick with the time at zero.
  a_expired_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && expired |-> accepted && digits == '0)
    else $error("expired with non-zero time");

  // Without an item moving into the result slot the state holds.
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(digits) && $stable(cursor))
    else $error("timer state changed without an item");

  // A stalled result slot is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !advance)
    else $error("result overwritten while stalled");

endmodule
